FILE: rtl/fkh_pkg.sv
// fkh_pkg: shared types, codes and the fnv-1a step for the feature keep unit
`timescale 1ns / 1ps
`default_nettype none

package fkh_pkg;

  // fnv-1a 64 constants
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam int unsigned FNV_BYTES  = 24;
  localparam int unsigned SEED_BYTES = 8;

  // q0.16 and q0.32 one
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // configuration register indexes
  localparam logic [1:0] CFG_LOW_THR  = 2'd0;
  localparam logic [1:0] CFG_HIGH_THR = 2'd1;
  localparam logic [1:0] CFG_FRACTION = 2'd2;
  localparam logic [1:0] CFG_SEED     = 2'd3;

  // weight codes
  localparam logic [1:0] WEIGHT_ZERO = 2'd0;
  localparam logic [1:0] WEIGHT_HALF = 2'd1;
  localparam logic [1:0] WEIGHT_ONE  = 2'd2;

  // reason codes
  localparam logic [1:0] REASON_LOW_KEEP    = 2'd0;
  localparam logic [1:0] REASON_HIGH_REMOVE = 2'd1;
  localparam logic [1:0] REASON_HASH_KEEP   = 2'd2;
  localparam logic [1:0] REASON_HASH_REMOVE = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SCORE_OOR = 2'd1;
  localparam logic [1:0] STATUS_BAD_CFG   = 2'd2;

  typedef struct packed {
    logic [16:0]        score;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [63:0]        frame_id;
  } fkh_in_t;

  typedef struct packed {
    logic       keep;
    logic [1:0] weight_code;
    logic [1:0] reason;
    logic [1:0] status;
  } fkh_out_t;

  // early decision carried along the hash pipeline
  typedef struct packed {
    logic       use_hash;
    logic       keep;
    logic [1:0] weight_code;
    logic [1:0] reason;
    logic [1:0] status;
  } fkh_dec_t;

  // one fnv-1a byte step; prime is 2^40 + 0x1b3, so the product is shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fkh_stream_if.sv
// fkh_stream_if: valid/ready channel carrying one payload item per transfer
`timescale 1ns / 1ps
`default_nettype none

interface fkh_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/fkh_classify.sv
// fkh_classify: score range, configuration and threshold decision at entry
`timescale 1ns / 1ps
`default_nettype none

module fkh_classify (
  input  wire logic [16:0]      score_i,
  input  wire logic [16:0]      low_thr_i,
  input  wire logic [16:0]      high_thr_i,
  input  wire logic [32:0]      fraction_i,
  output fkh_pkg::fkh_dec_t     dec_o
);
  import fkh_pkg::*;

  logic cfg_ok;

  // configuration is usable only with ordered thresholds and with high threshold and fraction in range
  assign cfg_ok = (low_thr_i < high_thr_i) && (high_thr_i <= ONE_Q16) &&
                  (fraction_i <= ONE_Q32);

  // priority: score range, configuration, low, high, hash sampling
  always_comb begin
    dec_o = '0;
    dec_o.weight_code = WEIGHT_ZERO;
    dec_o.reason      = REASON_LOW_KEEP;
    dec_o.status      = STATUS_OK;
    if (score_i > ONE_Q16) begin
      dec_o.status = STATUS_SCORE_OOR;
    end else if (!cfg_ok) begin
      dec_o.status = STATUS_BAD_CFG;
    end else if (score_i < low_thr_i) begin
      dec_o.keep        = 1'b1;
      dec_o.weight_code = WEIGHT_ONE;
      dec_o.reason      = REASON_LOW_KEEP;
    end else if (score_i >= high_thr_i) begin
      dec_o.keep        = 1'b0;
      dec_o.weight_code = WEIGHT_ZERO;
      dec_o.reason      = REASON_HIGH_REMOVE;
    end else begin
      dec_o.use_hash    = 1'b1;
      dec_o.weight_code = WEIGHT_HALF;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fkh_hash_pipe.sv
// fkh_hash_pipe: 24-stage fnv-1a 64 pipeline, one message byte per stage
`timescale 1ns / 1ps
`default_nettype none

module fkh_hash_pipe (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [63:0]       seed_i,
  input  wire logic [127:0]      tail_i,
  input  wire fkh_pkg::fkh_dec_t dec_i,
  output logic                   valid_o,
  output logic [63:0]            hash_o,
  output fkh_pkg::fkh_dec_t      dec_o
);
  import fkh_pkg::*;

  localparam int unsigned NS = FNV_BYTES;

  logic [NS-1:0] valid_q;
  logic [63:0]   hash_q [NS];
  logic [127:0]  tail_q [NS];
  fkh_dec_t      dec_q  [NS];

  // first stage mixes the low seed byte into the basis
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hash_q[0] <= fnv_step(FNV_BASIS, seed_i[7:0]);
      tail_q[0] <= tail_i;
      dec_q[0]  <= dec_i;
    end
  end

  // remaining stages: seed bytes from the register, then key, x, y from the tail
  for (genvar s = 1; s < NS; s++) begin : g_stage
    logic [7:0]   byte_in;
    logic [127:0] tail_next;

    if (s < SEED_BYTES) begin : g_seed
      assign byte_in   = seed_i[8*s +: 8];
      assign tail_next = tail_q[s-1];
    end else begin : g_tail
      assign byte_in   = tail_q[s-1][7:0];
      assign tail_next = tail_q[s-1] >> 8;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hash_q[s] <= fnv_step(hash_q[s-1], byte_in);
        tail_q[s] <= tail_next;
        dec_q[s]  <= dec_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign hash_o  = hash_q[NS-1];
  assign dec_o   = dec_q[NS-1];

endmodule

`default_nettype wire

FILE: rtl/feature_keep_hash_policy_unit.sv
// feature_keep_hash_policy_unit: top level with config registers and result stage
//
//   channel   dir   payload                                  transfer when
//   in_i      in    score, pos_x, pos_y, frame_id            valid && ready
//   out_o     out   keep, weight_code, reason, status        valid && ready
//   cfg_*     in    index, 64-bit data                       cfg_we_i high
//
// one feature per cycle unless halted; 24 hash stages (one fnv byte each,
// a 64-bit shift-and-add product per stage) feed one compare/result register.
// a two-entry result buffer lets the pipeline advance while a result waits;
// the pipeline halts only when both entries are full, and nothing is dropped.
// reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module feature_keep_hash_policy_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  fkh_stream_if.sink       in_i,
  fkh_stream_if.source     out_o
);
  import fkh_pkg::*;

  logic [16:0] low_thr_q;
  logic [16:0] high_thr_q;
  logic [32:0] fraction_q;
  logic [63:0] seed_q;

  fkh_in_t  in_data;
  fkh_dec_t in_dec;
  fkh_dec_t pipe_dec;
  logic     pipe_valid;
  logic [63:0] pipe_hash;
  logic     pipe_en;
  logic     hash_keep;
  fkh_out_t res;

  fkh_out_t out_q;
  logic     out_valid_q;
  fkh_out_t skid_q;
  logic     skid_valid_q;
  logic     out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= 17'd16384;
      high_thr_q <= 17'd49152;
      fraction_q <= 33'h0_8000_0000;
      seed_q     <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_THR:  low_thr_q  <= cfg_data_i[16:0];
        CFG_HIGH_THR: high_thr_q <= cfg_data_i[16:0];
        CFG_FRACTION: fraction_q <= cfg_data_i[32:0];
        CFG_SEED:     seed_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // entry decision
  assign in_data = in_i.data;

  fkh_classify u_classify (
    .score_i    (in_data.score),
    .low_thr_i  (low_thr_q),
    .high_thr_i (high_thr_q),
    .fraction_i (fraction_q),
    .dec_o      (in_dec)
  );

  // hash pipeline advances while the result buffer has room
  assign pipe_en     = !skid_valid_q;
  assign in_i.ready  = pipe_en;

  fkh_hash_pipe u_hash_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_i.valid),
    .seed_i  (seed_q),
    .tail_i  ({in_data.pos_y, in_data.pos_x, in_data.frame_id}),
    .dec_i   (in_dec),
    .valid_o (pipe_valid),
    .hash_o  (pipe_hash),
    .dec_o   (pipe_dec)
  );

  // hash < fraction * 2^32 exactly when the upper word is below the fraction
  assign hash_keep = {1'b0, pipe_hash[63:32]} < fraction_q;

  always_comb begin
    res.keep        = pipe_dec.keep;
    res.weight_code = pipe_dec.weight_code;
    res.reason      = pipe_dec.reason;
    res.status      = pipe_dec.status;
    if (pipe_dec.use_hash) begin
      res.keep   = hash_keep;
      res.reason = hash_keep ? REASON_HASH_KEEP : REASON_HASH_REMOVE;
    end
  end

  // output register with skid entry
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (pipe_valid) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (pipe_valid) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

FILE: tb/feature_keep_hash_policy_unit_tb.sv
// feature_keep_hash_policy_unit_tb: self-checking bench for the feature keep decision unit
`timescale 1ns / 1ps

module feature_keep_hash_policy_unit_tb;
  import fkh_pkg::*;

  localparam logic [63:0] FNV_PRIME        = 64'd1099511628211;
  localparam int unsigned DRAIN_CYCLES     = 30;
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned NUM_PHASES       = 10;
  localparam longint     TIMEOUT_NS        = 64'd5_000_000;

  // verdicts that can be read straight off the decision rules
  localparam fkh_out_t OUT_LOW_KEEP    = {1'b1, WEIGHT_ONE, REASON_LOW_KEEP, STATUS_OK};
  localparam fkh_out_t OUT_HIGH_REMOVE = {1'b0, WEIGHT_ZERO, REASON_HIGH_REMOVE, STATUS_OK};
  localparam fkh_out_t OUT_HASH_KEEP   = {1'b1, WEIGHT_HALF, REASON_HASH_KEEP, STATUS_OK};
  localparam fkh_out_t OUT_HASH_REMOVE = {1'b0, WEIGHT_HALF, REASON_HASH_REMOVE, STATUS_OK};
  // error verdicts carry cleared keep, weight and reason fields
  localparam fkh_out_t OUT_SCORE_OOR   = {1'b0, WEIGHT_ZERO, REASON_LOW_KEEP, STATUS_SCORE_OOR};
  localparam fkh_out_t OUT_BAD_CFG     = {1'b0, WEIGHT_ZERO, REASON_LOW_KEEP, STATUS_BAD_CFG};

  typedef struct {
    bit          is_cfg;
    logic [1:0]  cfg_idx;
    logic [63:0] cfg_val;
    fkh_in_t     feat;
    bit          want_given;
    fkh_out_t    want;
  } plan_row_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [1:0]  cfg_idx_i  = CFG_LOW_THR;
  logic [63:0] cfg_data_i = '0;

  fkh_stream_if #(.T(fkh_in_t))  feat_if ();
  fkh_stream_if #(.T(fkh_out_t)) verdict_if ();

  feature_keep_hash_policy_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (feat_if),
    .out_o      (verdict_if)
  );

  // shadow copy of the policy registers
  logic [16:0] thr_low_q16;
  logic [16:0] thr_high_q16;
  logic [32:0] keep_fraction_q32;
  logic [63:0] hash_seed;

  fkh_out_t    expected_verdicts[$];
  plan_row_t   directed_plan[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 1;
  bit          long_hold_req  = 1'b0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // decision for one feature under the shadow registers
  function automatic fkh_out_t predict_verdict(input fkh_in_t f);
    fkh_out_t     r;
    logic [63:0]  h;
    logic [191:0] msg;
    r = '0;
    if (f.score > ONE_Q16) begin
      r.status = STATUS_SCORE_OOR;
    end else if (!(thr_low_q16 < thr_high_q16 && thr_high_q16 <= ONE_Q16 &&
                   keep_fraction_q32 <= ONE_Q32)) begin
      r.status = STATUS_BAD_CFG;
    end else if (f.score < thr_low_q16) begin
      r.keep        = 1'b1;
      r.weight_code = WEIGHT_ONE;
      r.reason      = REASON_LOW_KEEP;
    end else if (f.score >= thr_high_q16) begin
      r.weight_code = WEIGHT_ZERO;
      r.reason      = REASON_HIGH_REMOVE;
    end else begin
      // fnv-1a over seed, key, x, y, each least significant byte first
      msg = {f.pos_y, f.pos_x, f.frame_id, hash_seed};
      h   = FNV_BASIS;
      for (int i = 0; i < 24; i++) begin
        h = (h ^ {56'd0, msg[8*i +: 8]}) * FNV_PRIME;
      end
      r.keep        = (h[63:32] < keep_fraction_q32);
      r.weight_code = WEIGHT_HALF;
      r.reason      = r.keep ? REASON_HASH_KEEP : REASON_HASH_REMOVE;
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_feat(input logic [16:0] score, input logic [31:0] px,
                          input logic [31:0] py, input logic [63:0] key,
                          input bit given, input fkh_out_t want);
    plan_row_t row;
    row               = '{default: '0};
    row.feat.score    = score;
    row.feat.pos_x    = px;
    row.feat.pos_y    = py;
    row.feat.frame_id = key;
    row.want_given    = given;
    row.want          = want;
    directed_plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [63:0] value);
    plan_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = value;
    directed_plan.push_back(row);
  endtask

  // single register write, mirrored into the shadow copy
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_LOW_THR:  thr_low_q16       = value[16:0];
      CFG_HIGH_THR: thr_high_q16      = value[16:0];
      CFG_FRACTION: keep_fraction_q32 = value[32:0];
      CFG_SEED:     hash_seed         = value;
      default: ;
    endcase
  endtask

  // stop offering and wait until every verdict is back and the pipe is empty
  task automatic drain_pipeline();
    feat_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // offer one feature and hold it until the transfer
  task automatic push_feature(input fkh_in_t item, input bit given, input fkh_out_t want);
    feat_if.valid <= 1'b1;
    feat_if.data  <= item;
    do @(posedge clk_i); while (!feat_if.ready);
    expected_verdicts.push_back(given ? want : predict_verdict(item));
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        feat_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [1:0] want_v,
                             input logic [1:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  // receiver: ready pattern in randomly picked modes, plus one long hold
  initial begin : sink_pattern
    int unsigned cyc;
    int unsigned mode;
    bit          rdy;
    cyc  = 0;
    mode = 0;
    verdict_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        verdict_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 1) == 1);
        2:       rdy = ($urandom_range(0, 9) == 0);
        default: rdy = ((cyc % 7) >= 3);
      endcase
      verdict_if.ready <= rdy;
      cyc++;
    end
  end

  // compare each verdict transfer with the oldest expectation
  always @(posedge clk_i) begin : verdict_check
    fkh_out_t want;
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: verdict mismatch, expected none, got %b", $time,
                 verdict_if.data);
      end else begin
        want = expected_verdicts.pop_front();
        check_field("keep", {1'b0, want.keep}, {1'b0, verdict_if.data.keep});
        check_field("weight_code", want.weight_code, verdict_if.data.weight_code);
        check_field("reason", want.reason, verdict_if.data.reason);
        check_field("status", want.status, verdict_if.data.status);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    fkh_in_t     item;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [32:0] fr;
    logic [63:0] sd;
    logic [63:0] upper;
    bit          bad;
    int unsigned sel;
    int unsigned n_items;

    feat_if.valid     <= 1'b0;
    feat_if.data      <= '0;
    thr_low_q16       = 17'd16384;
    thr_high_q16      = 17'd49152;
    keep_fraction_q32 = 33'h0_8000_0000;
    hash_seed         = '0;

    // directed plan: threshold boundaries, the sampled band and out-of-range scores under reset values
    add_feat(17'd0, 32'h0, 32'h0, 64'h0, 1'b1, OUT_LOW_KEEP);
    add_feat(17'd16383, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 1'b1, OUT_LOW_KEEP);
    add_feat(17'd16384, 32'h8000_0000, 32'h7FFF_FFFF, 64'h8000_0000_0000_0001, 1'b0, '0);
    add_feat(17'd49151, 32'h7FFF_FFFF, 32'h8000_0000, '1, 1'b0, '0);
    add_feat(17'd49152, 32'h0000_1234, 32'hFFFF_EDCC, 64'h0123_4567_89AB_CDEF,
             1'b1, OUT_HIGH_REMOVE);
    add_feat(17'd65536, 32'h0000_0001, 32'h0000_0002, 64'h5555_AAAA_5555_AAAA,
             1'b1, OUT_HIGH_REMOVE);
    add_feat(17'd65537, 32'h0000_0003, 32'h0000_0004, 64'h0, 1'b1, OUT_SCORE_OOR);
    add_feat(17'h1FFFF, '1, '1, '1, 1'b1, OUT_SCORE_OOR);
    // a fraction of one keeps every uncertain feature, zero keeps none
    add_cfg(CFG_FRACTION, {31'd0, ONE_Q32});
    add_feat(17'd30000, 32'd17, 32'd42, 64'hDEAD_BEEF_0000_0001, 1'b1, OUT_HASH_KEEP);
    add_feat(17'd16384, 32'hFFFF_FF00, 32'd9, 64'hFFFF_0000_FFFF_0000, 1'b1, OUT_HASH_KEEP);
    add_cfg(CFG_FRACTION, 64'd0);
    add_feat(17'd16384, 32'd5, 32'd6, 64'h1, 1'b1, OUT_HASH_REMOVE);
    add_feat(17'd49151, 32'h8000_0000, 32'h8000_0000, '1, 1'b1, OUT_HASH_REMOVE);
    // fraction above one is a bad setting; the range check still wins
    add_cfg(CFG_FRACTION, 64'h1_0000_0001);
    add_feat(17'd30000, 32'd1, 32'd1, 64'h2, 1'b1, OUT_BAD_CFG);
    add_feat(17'd65537, 32'd1, 32'd1, 64'h2, 1'b1, OUT_SCORE_OOR);
    // high threshold above one
    add_cfg(CFG_FRACTION, 64'h8000_0000);
    add_cfg(CFG_HIGH_THR, 64'd65537);
    add_feat(17'd0, 32'd7, 32'd8, 64'h3, 1'b1, OUT_BAD_CFG);
    // low threshold not below high threshold
    add_cfg(CFG_HIGH_THR, 64'd65536);
    add_cfg(CFG_LOW_THR, 64'd65536);
    add_feat(17'd100, 32'd7, 32'd8, 64'h3, 1'b1, OUT_BAD_CFG);
    // widest valid band
    add_cfg(CFG_LOW_THR, 64'd0);
    add_feat(17'd0, 32'h1234_5678, 32'h9ABC_DEF0, 64'hFEDC_BA98_7654_3210, 1'b0, '0);
    add_feat(17'd65535, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, '0);
    add_feat(17'd65536, 32'd0, 32'd0, 64'h0, 1'b1, OUT_HIGH_REMOVE);
    // seed of all ones, low threshold written with junk above bit 16
    add_cfg(CFG_SEED, '1);
    add_cfg(CFG_LOW_THR, 64'hFFFF_FFFF_FFFE_4E20);
    add_feat(17'd20000, 32'd100, 32'hFFFF_FF9C, 64'hCAFE_F00D_1234_5678, 1'b0, '0);
    add_feat(17'd19999, 32'd100, 32'hFFFF_FF9C, 64'hCAFE_F00D_1234_5678, 1'b1, OUT_LOW_KEEP);
    add_cfg(CFG_SEED, 64'h0123_4567_89AB_CDEF);
    add_feat(17'd40000, 32'hAAAA_5555, 32'h5555_AAAA, 64'h0000_0001_0000_0001, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        drain_pipeline();
        write_reg(directed_plan[i].cfg_idx, directed_plan[i].cfg_val);
      end else begin
        push_feature(directed_plan[i].feat, directed_plan[i].want_given,
                     directed_plan[i].want);
        pace_sender();
      end
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      lo    = 17'($urandom_range(0, 65535));
      hi    = 17'($urandom_range(lo + 1, 65536));
      fr    = {1'b0, $urandom};
      sd    = {$urandom, $urandom};
      upper = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
      bad   = 1'b0;
      case (ph)
        1: begin lo = '0; hi = ONE_Q16; fr = ONE_Q32; sd = '1; end
        2: begin fr = '0; sd = '0; end
        4: begin bad = 1'b1; lo = 17'($urandom_range(hi, 65536)); end
        7: begin bad = 1'b1; hi = '1; end
        9: begin bad = 1'b1; fr = '1; end
        default: ;
      endcase
      drain_pipeline();
      write_reg(CFG_LOW_THR, {upper[63:17], lo});
      write_reg(CFG_HIGH_THR, {upper[63:17], hi});
      write_reg(CFG_FRACTION, {upper[63:33], fr});
      write_reg(CFG_SEED, sd);

      n_items = bad ? 50 : 220;
      for (int k = 0; k < n_items; k++) begin
        // mostly scores in the sampled band, some below, above and out of range
        sel = $urandom_range(0, 9);
        if (bad || sel == 0) begin
          item.score = 17'($urandom_range(0, 131071));
        end else if (sel == 1 && thr_low_q16 != 0) begin
          item.score = 17'($urandom_range(0, thr_low_q16 - 1));
        end else if (sel == 2) begin
          item.score = 17'($urandom_range(thr_high_q16, 65536));
        end else begin
          item.score = 17'($urandom_range(thr_low_q16, thr_high_q16 - 1));
        end
        item.pos_x    = rand_coord();
        item.pos_y    = rand_coord();
        item.frame_id = {$urandom, $urandom};

        // back-pressure: receiver holds off while the sender keeps offering
        if (ph == 3 && k == 20) long_hold_req = 1'b1;
        // sender pauses until every verdict is back
        if (ph == 5 && k == 100) drain_pipeline();

        push_feature(item, 1'b0, '0);
        pace_sender();
      end
    end

    drain_pipeline();
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fkh_pkg.sv
rtl/fkh_stream_if.sv
rtl/fkh_classify.sv
rtl/fkh_hash_pipe.sv
rtl/feature_keep_hash_policy_unit.sv
tb/feature_keep_hash_policy_unit_tb.sv
